// ===== hdl/io_expansion_bus_master_defines.svh =====
// assertion macros for the i/o expansion bus master
// used by io_expansion_bus_master; expects clk and arst_n in scope
`ifndef IO_EXPANSION_BUS_MASTER_DEFINES_SVH
`define IO_EXPANSION_BUS_MASTER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define IEBM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("iebm check failed");

// next-cycle implication, disabled during reset
`define IEBM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("iebm check failed");

`endif

// ===== hdl/iebm_pkg.sv =====
// shared types and constants for the i/o expansion bus master
// no dependencies
package iebm_pkg;

	localparam int unsigned CountW = 16;
	localparam int unsigned ByteW = 8;
	localparam logic [CountW-1:0] TimeoutReset = 16'hFFFF;
	localparam logic [ByteW-1:0] PullUpByte = 8'hFF;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_READ  = 2'd2,
		ACT_RSVD  = 2'd3
	} action_t;

	typedef enum logic [4:0] {
		PH_IDLE      = 5'b00001,
		PH_ADDR_WAIT = 5'b00010,
		PH_ADDR_REL  = 5'b00100,
		PH_DATA_WAIT = 5'b01000,
		PH_DATA_REL  = 5'b10000
	} phase_t;

	// input item payload, last field in the lowest bits
	typedef struct packed {
		logic [ByteW-1:0] bus_pins;
		logic             ready_pin;
		logic [ByteW-1:0] write_data;
		logic [ByteW-1:0] port_addr;
	} in_item_t;

	// result item payload, last field in the lowest bits
	typedef struct packed {
		logic [ByteW-1:0] read_result;
		logic             timed_out;
		logic             done_res;
		logic             busy_res;
		logic             bus_drive;
		logic [ByteW-1:0] bus_out;
		logic             read_mode;
		logic             address_phase;
		logic             enable_n;
	} res_item_t;

	localparam int unsigned InBits = $bits(in_item_t);
	localparam int unsigned ResBits = $bits(res_item_t);
	localparam int unsigned InDataW = ((InBits + 7) / 8) * 8;
	localparam int unsigned ResDataW = ((ResBits + 7) / 8) * 8;

endpackage

// ===== hdl/io_expansion_bus_master.sv =====
// top level of the i/o expansion bus master: ready filter, access sequencer, result stage
// depends on iebm_pkg and io_expansion_bus_master_defines.svh
//
// usage
//   s_* channel: one transaction per bus clock tick with the sampled ready and data
//     pins; s_tuser carries the action (tick only, start write, start read)
//   m_* channel: one result transaction per input transaction with the strobe,
//     bus drive levels and, on the finishing tick, done, timeout flag and read byte
//   cfg_we / cfg_wdata: writes the address-phase timeout limit in ticks
// a tick passes through the input register and then the result register
// throughput: one tick per cycle while m_tready is high; the sequencer state advances as the tick moves
//   from the input register into the result register
// reset: sequencer idle in read mode, ready filter not ready, timeout limit 65535,
//   both registers empty
// stall: while m_tready is low the result register holds; the input register still
//   fills once, then s_tready drops until the result is taken
`include "io_expansion_bus_master_defines.svh"

module io_expansion_bus_master
	import iebm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CountW-1:0]   cfg_wdata,
	input  logic                s_tvalid,
	output logic                s_tready,
	// port_addr, write_data, ready_pin, bus_pins, zero fill
	input  logic [InDataW-1:0]  s_tdata,
	// action
	input  logic [1:0]          s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// enable_n, address_phase, read_mode, bus_out, bus_drive, busy_res, done_res,
	// timed_out, read_result, zero fill
	output logic [ResDataW-1:0] m_tdata
);

	logic [CountW-1:0] tmo_limit_q;
	phase_t            phase_q;
	logic [CountW-1:0] wait_cnt_q;
	logic              last_rdy_q;
	logic              filt_rdy_q;
	logic              is_read_q;
	logic [ByteW-1:0]  port_q;
	logic [ByteW-1:0]  value_q;
	logic [ByteW-1:0]  rd_byte_q;

	logic              in_vld_s1;
	in_item_t          in_s1;
	action_t           act_s1;
	logic              out_vld_s2;
	res_item_t         out_s2;

	phase_t            phase_d;
	logic [CountW-1:0] wait_cnt_d;
	logic [CountW-1:0] wait_inc;
	logic              filt_rdy_d;
	logic              is_read_d;
	logic [ByteW-1:0]  port_d;
	logic [ByteW-1:0]  value_d;
	logic [ByteW-1:0]  rd_byte_d;
	res_item_t         res_d;
	logic              advance;

	assign advance  = in_vld_s1 && (!out_vld_s2 || m_tready);
	assign s_tready = !in_vld_s1 || advance;
	assign m_tvalid = out_vld_s2;
	assign m_tdata  = {{(ResDataW-ResBits){1'b0}}, out_s2};
	assign wait_inc = wait_cnt_q + 1'b1;

	always_comb begin
		filt_rdy_d = (in_s1.ready_pin == last_rdy_q) ? !in_s1.ready_pin : filt_rdy_q;
		phase_d    = phase_q;
		wait_cnt_d = wait_cnt_q;
		is_read_d  = is_read_q;
		port_d     = port_q;
		value_d    = value_q;
		rd_byte_d  = rd_byte_q;
		res_d      = '0;

		case (phase_q)
			PH_IDLE: begin
				if (act_s1 == ACT_WRITE || act_s1 == ACT_READ) begin
					is_read_d  = (act_s1 == ACT_READ);
					port_d     = in_s1.port_addr;
					value_d    = in_s1.write_data;
					rd_byte_d  = PullUpByte;
					wait_cnt_d = '0;
					phase_d    = PH_ADDR_WAIT;
				end
			end
			PH_ADDR_WAIT: begin
				if (filt_rdy_d) begin
					phase_d = PH_ADDR_REL;
				end else begin
					wait_cnt_d = wait_inc;
					if (wait_inc >= tmo_limit_q) begin
						phase_d           = PH_IDLE;
						res_d.done_res    = 1'b1;
						res_d.timed_out   = 1'b1;
						res_d.read_result = PullUpByte;
						rd_byte_d         = PullUpByte;
						is_read_d         = 1'b1;
					end
				end
			end
			PH_ADDR_REL: begin
				if (!filt_rdy_d) begin
					phase_d = PH_DATA_WAIT;
				end
			end
			PH_DATA_WAIT: begin
				if (filt_rdy_d) begin
					if (is_read_q) begin
						rd_byte_d = in_s1.bus_pins;
					end
					phase_d = PH_DATA_REL;
				end
			end
			PH_DATA_REL: begin
				if (!filt_rdy_d) begin
					phase_d           = PH_IDLE;
					res_d.done_res    = 1'b1;
					res_d.read_result = is_read_q ? rd_byte_q : '0;
					is_read_d         = 1'b1;
				end
			end
			default: begin
				phase_d   = PH_IDLE;
				is_read_d = 1'b1;
			end
		endcase

		res_d.enable_n      = !(phase_d == PH_ADDR_WAIT || phase_d == PH_DATA_WAIT);
		res_d.address_phase = (phase_d == PH_ADDR_WAIT || phase_d == PH_ADDR_REL);
		res_d.busy_res      = (phase_d != PH_IDLE);
		res_d.read_mode     = res_d.busy_res ? is_read_d : 1'b1;
		if (res_d.address_phase) begin
			res_d.bus_out   = port_d;
			res_d.bus_drive = 1'b1;
		end else if (res_d.busy_res) begin
			res_d.bus_out   = is_read_d ? PullUpByte : value_d;
			res_d.bus_drive = !is_read_d;
		end else begin
			res_d.bus_out   = '0;
			res_d.bus_drive = 1'b0;
		end
	end

	// timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmo_limit_q <= TimeoutReset;
		end else if (cfg_we) begin
			tmo_limit_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1 <= 1'b0;
		end else if (s_tready) begin
			in_vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_s1  <= in_item_t'(s_tdata[InBits-1:0]);
			act_s1 <= action_t'(s_tuser);
		end
	end

	// sequencer state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			wait_cnt_q <= '0;
			last_rdy_q <= 1'b1;
			filt_rdy_q <= 1'b0;
			is_read_q  <= 1'b1;
			port_q     <= '0;
			value_q    <= '0;
			rd_byte_q  <= PullUpByte;
			out_vld_s2 <= 1'b0;
		end else begin
			if (advance) begin
				phase_q    <= phase_d;
				wait_cnt_q <= wait_cnt_d;
				last_rdy_q <= in_s1.ready_pin;
				filt_rdy_q <= filt_rdy_d;
				is_read_q  <= is_read_d;
				port_q     <= port_d;
				value_q    <= value_d;
				rd_byte_q  <= rd_byte_d;
				out_vld_s2 <= 1'b1;
			end else if (m_tready) begin
				out_vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_s2 <= res_d;
		end
	end

	`IEBM_ASSERT_NOW(a_done_not_busy, out_vld_s2 && out_s2.done_res, !out_s2.busy_res)
	`IEBM_ASSERT_NOW(a_tmo_result, out_vld_s2 && out_s2.timed_out, out_s2.done_res && out_s2.read_result == PullUpByte)
	`IEBM_ASSERT_NOW(a_strobe_busy, out_vld_s2 && !out_s2.enable_n, out_s2.busy_res)
	`IEBM_ASSERT_NEXT(a_idle_after_done, advance && res_d.done_res, phase_q == PH_IDLE)

endmodule
